[hdl/mnhf_pkg.sv]
// Shared types, constants and the reciprocal table for the masked neighbour hole fill unit.
package mnhf_pkg;

  // Store geometry
  localparam int unsigned MaxSamples = 65536;
  localparam int unsigned AddrW      = $clog2(MaxSamples);
  localparam int unsigned LimitW     = AddrW + 1;
  localparam int unsigned IdxW       = AddrW + 2;

  // Register widths
  localparam int unsigned RowW   = 13;
  localparam int unsigned ChanW  = 3;
  localparam int unsigned CountW = 17;
  localparam int unsigned CfgW   = 17;
  localparam int unsigned CfgIdxW = 2;

  // Datapath widths
  localparam int unsigned SampleW = 8;
  localparam int unsigned CountNW = 4;
  localparam int unsigned OffW    = 16;
  localparam int unsigned NumW    = 11;
  localparam int unsigned RecipW  = 17;
  localparam int unsigned ProdW   = NumW + RecipW;
  localparam int unsigned RecipShift = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgRowPixels   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgChannels    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSampleCount = 2'd2;

  // Reset values
  localparam logic [RowW-1:0]   RowPixelsRst   = 13'd256;
  localparam logic [ChanW-1:0]  ChannelsRst    = 3'd3;
  localparam logic [CountW-1:0] SampleCountRst = 17'd65536;

  // Command codes
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdRead  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [AddrW-1:0]   address;
    logic [SampleW-1:0] sample_in;
    logic               marked_in;
  } in_item_t;

  typedef struct packed {
    logic [SampleW-1:0] sample_out;
    logic [CountNW-1:0] neighbours_used;
    logic [AddrW-1:0]   address_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OWN,
    ST_NB_RD,
    ST_NB_ACC,
    ST_NB_DIV,
    ST_DONE
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic write_en;
    logic start_read;
    logic nb_read;
    logic nb_acc;
    logic nb_div;
    logic k_inc;
    logic res_load;
    logic res_sel_own;
  } ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic own_oob;
    logic own_mark;
    logic nb_use;
    logic k_last;
  } status_t;

  // ceil(2^16 / (n+1)) for n = 0..7; exact quotient for numerators below 2048
  function automatic logic [RecipW-1:0] recip(input logic [2:0] n);
    logic [RecipW-1:0] r;
    begin
      case (n)
        3'd0:    r = 17'd65536;
        3'd1:    r = 17'd32768;
        3'd2:    r = 17'd21846;
        3'd3:    r = 17'd16384;
        3'd4:    r = 17'd13108;
        3'd5:    r = 17'd10923;
        3'd6:    r = 17'd9363;
        3'd7:    r = 17'd8192;
        default: r = 17'd65536;
      endcase
      return r;
    end
  endfunction

endpackage

[hdl/mnhf_ctrl.sv]
// Controller state machine for the masked neighbour hole fill unit.
module mnhf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_cmd_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  mnhf_pkg::status_t status_i,
  output mnhf_pkg::ctrl_t   ctrl_o
);
  import mnhf_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   sel_own_q, sel_own_d;
  logic   in_xfer;
  logic   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sel_own_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sel_own_q   <= sel_own_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    sel_own_d = sel_own_q;
    ctrl_o    = '0;
    ctrl_o.res_sel_own = sel_own_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_cmd_i == CmdWrite) begin
            ctrl_o.write_en = 1'b1;
          end else begin
            ctrl_o.start_read = 1'b1;
            state_d = ST_OWN;
          end
        end
      end
      ST_OWN: begin
        sel_own_d = status_i.own_mark && !status_i.own_oob;
        if (status_i.own_oob || status_i.own_mark) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_NB_RD;
        end
      end
      ST_NB_RD: begin
        ctrl_o.nb_read = 1'b1;
        state_d = ST_NB_ACC;
      end
      ST_NB_ACC: begin
        ctrl_o.nb_acc = 1'b1;
        if (status_i.nb_use) begin
          state_d = ST_NB_DIV;
        end else if (status_i.k_last) begin
          state_d = ST_DONE;
        end else begin
          ctrl_o.k_inc = 1'b1;
          state_d = ST_NB_RD;
        end
      end
      ST_NB_DIV: begin
        ctrl_o.nb_div = 1'b1;
        if (status_i.k_last) begin
          state_d = ST_DONE;
        end else begin
          ctrl_o.k_inc = 1'b1;
          state_d = ST_NB_RD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ctrl_o.res_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_read_enters_own: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_cmd_i == CmdRead) |=> (state_q == ST_OWN))
    else $error("read transfer did not start the own-entry check");

  a_div_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NB_DIV) |-> ($past(state_q) == ST_NB_ACC))
    else $error("divide step without a preceding accumulate");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.res_load |=> out_valid_q)
    else $error("result load did not raise output valid");
`endif

endmodule

[hdl/mnhf_dp.sv]
// Datapath for the masked neighbour hole fill unit: registers, sample store, mean unit.
module mnhf_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mnhf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mnhf_pkg::CfgW-1:0]    cfg_data_i,
  input  mnhf_pkg::in_item_t           in_data_i,
  input  mnhf_pkg::ctrl_t              ctrl_i,
  output mnhf_pkg::status_t            status_o,
  output mnhf_pkg::out_item_t          out_data_o
);
  import mnhf_pkg::*;

  // Configuration
  logic [RowW-1:0]   row_pixels_q;
  logic [ChanW-1:0]  channels_q;
  logic [CountW-1:0] sample_count_q;
  logic [LimitW-1:0] limit;

  // Store: {mark, sample}
  logic [SampleW:0]  mem_q [MaxSamples];
  logic [SampleW:0]  rd_q;
  logic [AddrW-1:0]  mem_addr;
  logic              mem_re;

  // Read context
  logic [AddrW-1:0]  addr_q;
  logic [OffW-1:0]   m_q, m_d;
  logic [2:0]        k_q;
  logic              inrange_q;
  logic [NumW-1:0]   num_q, num_d;
  logic [SampleW-1:0] avg_q;
  logic [CountNW-1:0] n_q;
  logic [ProdW-1:0]  prod;
  out_item_t         out_q;

  logic signed [IdxW-1:0] sm, sc, off, idx;
  logic                   idx_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pixels_q   <= RowPixelsRst;
      channels_q     <= ChannelsRst;
      sample_count_q <= SampleCountRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgRowPixels:   row_pixels_q   <= cfg_data_i[RowW-1:0];
        CfgChannels:    channels_q     <= cfg_data_i[ChanW-1:0];
        CfgSampleCount: sample_count_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the bound at the store depth
  assign limit = (sample_count_q > CountW'(MaxSamples)) ? LimitW'(MaxSamples)
                                                        : LimitW'(sample_count_q);

  // Neighbour offset for step k
  assign sm = $signed({2'b00, m_q});
  assign sc = $signed({{(IdxW-ChanW){1'b0}}, channels_q});
  always_comb begin
    case (k_q)
      3'd0:    off = sc - sm;
      3'd1:    off = -sm;
      3'd2:    off = -sm - sc;
      3'd3:    off = -sc;
      3'd4:    off = sc;
      3'd5:    off = sm - sc;
      3'd6:    off = sm;
      3'd7:    off = sm + sc;
      default: off = sc;
    endcase
  end
  assign idx    = $signed({2'b00, addr_q}) + off;
  assign idx_in = !idx[IdxW-1] && (idx[LimitW-1:0] < limit);

  assign mem_addr = ctrl_i.nb_read ? idx[AddrW-1:0] : in_data_i.address;
  assign mem_re   = ctrl_i.start_read || ctrl_i.nb_read;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write_en) begin
      mem_q[mem_addr] <= {in_data_i.marked_in, in_data_i.sample_in};
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_addr];
    end
  end

  assign m_d   = OffW'({{ChanW{1'b0}}, row_pixels_q} * {{RowW{1'b0}}, channels_q});
  assign num_d = NumW'({{(NumW-3){1'b0}}, n_q[2:0]} * {{(NumW-SampleW){1'b0}}, avg_q})
               + {{(NumW-SampleW){1'b0}}, rd_q[SampleW-1:0]};
  assign prod  = ProdW'({{RecipW{1'b0}}, num_q} * {{NumW{1'b0}}, recip(n_q[2:0])});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
      n_q <= '0;
    end else begin
      if (ctrl_i.start_read) begin
        k_q <= '0;
        n_q <= '0;
      end else begin
        if (ctrl_i.k_inc) begin
          k_q <= k_q + 3'd1;
        end
        if (ctrl_i.nb_div) begin
          n_q <= n_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start_read) begin
      addr_q <= in_data_i.address;
      m_q    <= m_d;
      avg_q  <= '0;
    end
    if (ctrl_i.nb_read) begin
      inrange_q <= idx_in;
    end
    if (ctrl_i.nb_acc) begin
      num_q <= num_d;
    end
    if (ctrl_i.nb_div) begin
      avg_q <= prod[RecipShift +: SampleW];
    end
    if (ctrl_i.res_load) begin
      out_q.address_out <= addr_q;
      if (ctrl_i.res_sel_own) begin
        out_q.sample_out      <= rd_q[SampleW-1:0];
        out_q.neighbours_used <= '0;
      end else begin
        out_q.sample_out      <= avg_q;
        out_q.neighbours_used <= n_q;
      end
    end
  end

  assign status_o.own_oob  = ({1'b0, addr_q} >= limit);
  assign status_o.own_mark = rd_q[SampleW];
  assign status_o.nb_use   = inrange_q && rd_q[SampleW];
  assign status_o.k_last   = (k_q == 3'd7);
  assign out_data_o        = out_q;

`ifndef NO_ASSERTIONS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= 4'd8)
    else $error("neighbour count above eight");

  a_div_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.nb_div |=> (n_q == $past(n_q) + 4'd1))
    else $error("divide step did not advance the neighbour count");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start_read |=> (n_q == 4'd0 && avg_q == 8'd0 && k_q == 3'd0))
    else $error("read start left stale mean state");
`endif

endmodule

[hdl/masked_neighbour_hole_fill_unit.sv]
// Top level of the masked neighbour hole fill unit: controller plus datapath.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+--------------------------------------
//  in      | in        | in_valid/in_stall  | in_item_t: cmd, address, sample, mark
//  out     | out       | out_valid/out_stall| out_item_t: sample, count, address
//  cfg     | in        | cfg_we             | cfg_index, cfg_data (no read-back)
//
// A write is stored at the clock edge of its transfer. A read checks its own
// entry first: a marked sample is handed over as stored, an out-of-bound one
// as zero. Otherwise the single port of the sample store is read once per
// neighbour, each read followed by an accumulate and, for a marked in-range
// neighbour, a reciprocal divide. Input stalls until the result is loaded.
// Reset clears the controller and restores the registers; the store holds
// whatever it held. A stalled output holds its result while writes still go on.
module masked_neighbour_hole_fill_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mnhf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mnhf_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  mnhf_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output mnhf_pkg::out_item_t          out_data_o
);
  import mnhf_pkg::*;

  // Command and status between the sequencer and the datapath
  ctrl_t   ctrl;
  status_t status;

  // Sequence each read: own entry, eight neighbours of an in-range hole, hand over
  mnhf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  // Hold the registers, the store, the running mean and the output register
  mnhf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

[dv/masked_neighbour_hole_fill_unit_tb.sv]
// Self-checking testbench for the masked neighbour hole fill unit.
module masked_neighbour_hole_fill_unit_tb;
  import mnhf_pkg::*;

  // Cycles to let pass after the last result before touching the registers
  // or ending the run.
  localparam int unsigned SettleCycles = 32;
  // Cycles without any transfer before the run is declared hung. The long
  // receiver hold-off below is HoldCycles, so keep well clear of it.
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned HoldCycles   = 400;

  // Directed rows: the transfer to send, and a typed-in result where one is
  // obvious; other reads fall back to the predictor.
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CfgRowPixels;
  logic [CfgW-1:0]    cfg_data  = '0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  // Shadow of the image store and the registers, kept by the predictor
  logic [SampleW-1:0] shadow_sample [MaxSamples];
  logic               shadow_mark   [MaxSamples];
  bit                 shadow_written [MaxSamples];
  logic [RowW-1:0]    row_px;
  logic [ChanW-1:0]   chan_n;
  logic [CountW-1:0]  count_lim;

  out_item_t   expected_fills [$];
  int unsigned errors      = 0;
  int unsigned mark_pct    = 50;
  int unsigned idle_cycles = 0;
  bit          calm        = 1'b0;  // no idling on either side
  bit          hold_long   = 1'b0;  // ask the receiver for one long hold-off

  // Directed part, run with the reset register values (256, 3, 65536).
  stim_row_t dir_tab [20] = '{
    // marked sample at the bottom of the store comes back as stored
    {CmdWrite, 16'd0,     8'hFF, 1'b1, 1'b0, 8'h00, 4'd0, 16'd0},
    {CmdRead,  16'd0,     8'h00, 1'b0, 1'b1, 8'hFF, 4'd0, 16'd0},
    // marked sample at the top of the store
    {CmdWrite, 16'd65535, 8'h00, 1'b1, 1'b0, 8'h00, 4'd0, 16'd0},
    {CmdRead,  16'd65535, 8'h00, 1'b0, 1'b1, 8'h00, 4'd0, 16'd65535},
    // hole whose in-range neighbours are all holes: yields zero
    {CmdWrite, 16'd65534, 8'hAA, 1'b0, 1'b0, 8'h00, 4'd0, 16'd0},
    {CmdWrite, 16'd65531, 8'h55, 1'b0, 1'b0, 8'h00, 4'd0, 16'd0},
    {CmdWrite, 16'd64769, 8'h00, 1'b0, 1'b0, 8'h00, 4'd0, 16'd0},
    {CmdWrite, 16'd64766, 8'hFF, 1'b0, 1'b0, 8'h00, 4'd0, 16'd0},
    {CmdWrite, 16'd64763, 8'h12, 1'b0, 1'b0, 8'h00, 4'd0, 16'd0},
    {CmdRead,  16'd65534, 8'h00, 1'b0, 1'b1, 8'h00, 4'd0, 16'd65534},
    // hole near the bottom edge: upper-row offsets fall below zero
    {CmdWrite, 16'd3,     8'hC3, 1'b0, 1'b0, 8'h00, 4'd0, 16'd0},
    {CmdWrite, 16'd6,     8'h01, 1'b1, 1'b0, 8'h00, 4'd0, 16'd0},
    {CmdWrite, 16'd768,   8'h80, 1'b1, 1'b0, 8'h00, 4'd0, 16'd0},
    {CmdWrite, 16'd771,   8'h33, 1'b0, 1'b0, 8'h00, 4'd0, 16'd0},
    {CmdWrite, 16'd774,   8'hFE, 1'b1, 1'b0, 8'h00, 4'd0, 16'd0},
    {CmdRead,  16'd3,     8'h00, 1'b0, 1'b0, 8'h00, 4'd0, 16'd0},
    // sample and mark fields on a read must be ignored
    {CmdRead,  16'd3,     8'hFF, 1'b1, 1'b0, 8'h00, 4'd0, 16'd0},
    // overwrite a marked sample
    {CmdWrite, 16'd0,     8'h7F, 1'b1, 1'b0, 8'h00, 4'd0, 16'd0},
    {CmdRead,  16'd0,     8'h00, 1'b0, 1'b1, 8'h7F, 4'd0, 16'd0},
    {CmdRead,  16'd6,     8'h00, 1'b0, 1'b1, 8'h01, 4'd0, 16'd6}
  };

  masked_neighbour_hole_fill_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Neighbour bound: sample_count saturated at the store size.
  function automatic longint store_limit();
    if (longint'(count_lim) > longint'(MaxSamples)) return longint'(MaxSamples);
    return longint'(count_lim);
  endfunction

  // Linear offset of neighbour k, in the order the block visits them:
  // upper row, left, right, lower row.
  function automatic longint nb_offset(int k);
    longint rp;
    longint ch;
    rp = longint'(row_px);
    ch = longint'(chan_n);
    case (k)
      0:       return -(rp - 1) * ch;
      1:       return -rp * ch;
      2:       return -(rp + 1) * ch;
      3:       return -ch;
      4:       return ch;
      5:       return (rp - 1) * ch;
      6:       return rp * ch;
      default: return (rp + 1) * ch;
    endcase
  endfunction

  // Filled value for one read address under the current registers.
  function automatic out_item_t predict_fill(logic [AddrW-1:0] addr);
    out_item_t   res;
    longint      lim;
    longint      idx;
    int unsigned avg;
    int unsigned n;
    res = '0;
    res.address_out = addr;
    lim = store_limit();
    avg = 0;
    n   = 0;
    if (longint'(addr) >= lim) return res;
    if (shadow_mark[addr]) begin
      res.sample_out = shadow_sample[addr];
      return res;
    end
    // running mean, truncated after every step
    for (int k = 0; k < 8; k++) begin
      idx = longint'(addr) + nb_offset(k);
      if (idx >= 0 && idx < lim && shadow_mark[idx[AddrW-1:0]]) begin
        avg = (n * avg + shadow_sample[idx[AddrW-1:0]]) / (n + 1);
        n++;
      end
    end
    res.sample_out      = avg[SampleW-1:0];
    res.neighbours_used = n[CountNW-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Offer one transfer, predict its effect, and hold it until accepted.
  task automatic push_transfer(input in_item_t item, input logic typed,
                               input out_item_t want);
    // random gap before the item, never in the calm tail
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    if (item.cmd == CmdWrite) begin
      shadow_sample[item.address]  = item.sample_in;
      shadow_mark[item.address]    = item.marked_in;
      shadow_written[item.address] = 1'b1;
    end else begin
      expected_fills.push_back(typed ? want : predict_fill(item.address));
    end
    // hold the payload until the block takes it
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic send_write(input logic [AddrW-1:0] addr, input logic [SampleW-1:0] val,
                            input logic mark);
    in_item_t item;
    item           = '0;
    item.cmd       = CmdWrite;
    item.address   = addr;
    item.sample_in = val;
    item.marked_in = mark;
    push_transfer(item, 1'b0, '0);
  endtask

  function automatic logic rand_mark();
    return ($urandom_range(0, 99) < mark_pct);
  endfunction

  // Write the read address and every neighbour the block will visit, where
  // not yet written, then issue the read itself.
  task automatic prime_and_read(input logic [AddrW-1:0] addr);
    in_item_t item;
    longint   lim;
    longint   idx;
    lim = store_limit();
    if (!shadow_written[addr]) send_write(addr, 8'($urandom_range(0, 255)), rand_mark());
    if (longint'(addr) < lim && !shadow_mark[addr]) begin
      for (int k = 0; k < 8; k++) begin
        idx = longint'(addr) + nb_offset(k);
        if (idx >= 0 && idx < lim && !shadow_written[idx[AddrW-1:0]])
          send_write(idx[AddrW-1:0], 8'($urandom_range(0, 255)), rand_mark());
      end
    end
    item           = '0;
    item.cmd       = CmdRead;
    item.address   = addr;
    item.sample_in = 8'($urandom_range(0, 255));
    item.marked_in = 1'($urandom_range(0, 1));
    push_transfer(item, 1'b0, '0);
  endtask

  // Mostly addresses in a small working window, so neighbours get reused;
  // some anywhere, some at or above the bound.
  function automatic logic [AddrW-1:0] pick_addr(longint lim, int unsigned base,
                                                 int unsigned span);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10 || lim == 0) return AddrW'($urandom_range(0, MaxSamples - 1));
    if (roll < 20 && lim < MaxSamples)
      return AddrW'($urandom_range(int'(lim), MaxSamples - 1));
    return AddrW'((base + $urandom_range(0, span)) % lim);
  endfunction

  // Drop valid, wait for every outstanding result, then let the block settle.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_fills.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Program all three registers back to back; the block is idle here.
  task automatic program_regs(input int unsigned rows, input int unsigned chans,
                              input int unsigned count);
    cfg_we    <= 1'b1;
    cfg_index <= CfgRowPixels;
    cfg_data  <= CfgW'(rows);
    @(posedge clk);
    cfg_index <= CfgChannels;
    cfg_data  <= CfgW'(chans);
    @(posedge clk);
    cfg_index <= CfgSampleCount;
    cfg_data  <= CfgW'(count);
    @(posedge clk);
    cfg_we    <= 1'b0;
    row_px    = RowW'(rows);
    chan_n    = ChanW'(chans);
    count_lim = CountW'(count);
  endtask

  // One setting of the registers: bursts of loose writes, each followed by
  // a primed read, the well-formed sequence the block is built for.
  task automatic run_phase(input int unsigned rows, input int unsigned chans,
                           input int unsigned count, input int unsigned pct,
                           input int unsigned reads);
    longint      lim;
    int unsigned base;
    int unsigned span;
    program_regs(rows, chans, count);
    mark_pct = pct;
    lim      = store_limit();
    base     = (lim > 0) ? $urandom_range(0, int'(lim) - 1) : 0;
    span     = $urandom_range(8, 96);
    for (int r = 0; r < reads; r++) begin
      repeat ($urandom_range(0, 2))
        send_write(pick_addr(lim, base, span), 8'($urandom_range(0, 255)), rand_mark());
      prime_and_read(pick_addr(lim, base, span));
    end
    settle();
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    row_px    = RowPixelsRst;
    chan_n    = ChannelsRst;
    count_lim = SampleCountRst;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(dir_tab); i++)
      push_transfer(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
    settle();

    // extremes of every register, then the odd settings
    run_phase(4096, 4, 65536, 55, 30);
    run_phase(1, 1, 1, 50, 10);
    run_phase(0, 0, 0, 50, 10);          // every read outside the bound
    run_phase(8191, 7, 131071, 70, 20);  // count saturates at the store size
    run_phase(4, 2, 64, 100, 25);        // all neighbours marked
    run_phase(3, 1, 48, 0, 15);          // no marked neighbour anywhere
    run_phase(0, 3, 256, 60, 15);        // zero width: offsets coincide
    run_phase(5, 0, 200, 60, 10);        // zero channels: offsets hit the hole itself

    // back-pressure: the receiver holds off while reads keep coming
    hold_long = 1'b1;
    run_phase($urandom_range(1, 32), $urandom_range(1, 4), $urandom_range(16, 2048),
              60, 40);
    run_phase($urandom_range(1, 4096), $urandom_range(1, 4), $urandom_range(1, 65536),
              $urandom_range(30, 90), 20);
    run_phase($urandom_range(1, 32), $urandom_range(1, 4), $urandom_range(16, 2048),
              $urandom_range(30, 90), 20);

    // calm tail: no idling on either side
    calm = 1'b1;
    run_phase($urandom_range(1, 32), $urandom_range(1, 4), $urandom_range(16, 2048),
              $urandom_range(30, 90), 20);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------

  // Stall in random bursts; one long hold-off on request; none when calm.
  initial begin
    int unsigned stretch;
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        out_stall <= 1'b1;
        stretch   = HoldCycles;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        stretch   = $urandom_range(1, 14);
      end else begin
        out_stall <= 1'b0;
        stretch   = $urandom_range(1, 20);
      end
      repeat (stretch) @(posedge clk);
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_fills.size() == 0) begin
        $display("%0t: result for address %0d with none expected", $time,
                 out_data.address_out);
        errors++;
      end else begin
        exp_item = expected_fills.pop_front();
        if (out_data.sample_out !== exp_item.sample_out) begin
          $display("%0t: sample_out expected %0d got %0d (address %0d)", $time,
                   exp_item.sample_out, out_data.sample_out, exp_item.address_out);
          errors++;
        end
        if (out_data.neighbours_used !== exp_item.neighbours_used) begin
          $display("%0t: neighbours_used expected %0d got %0d (address %0d)", $time,
                   exp_item.neighbours_used, out_data.neighbours_used,
                   exp_item.address_out);
          errors++;
        end
        if (out_data.address_out !== exp_item.address_out) begin
          $display("%0t: address_out expected %0d got %0d", $time,
                   exp_item.address_out, out_data.address_out);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if no transfer moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

[masked_neighbour_hole_fill_unit.f]
hdl/mnhf_pkg.sv
hdl/mnhf_ctrl.sv
hdl/mnhf_dp.sv
hdl/masked_neighbour_hole_fill_unit.sv
dv/masked_neighbour_hole_fill_unit_tb.sv
